[sv/fax_pkg.sv]
package fax_pkg;

  localparam int unsigned FIELD_COLS      = 5;   // column fields on the row transaction
  localparam int unsigned DEF_MAX_COLUMNS = 5;
  localparam int unsigned FMA_LAT         = 9;   // register stages in one fused multiply-add
  localparam int unsigned COL_IDX_W       = 3;

  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [62:0] INF_MAG   = 63'h7FF0_0000_0000_0000;

  typedef logic signed [13:0] expo_t;

  typedef enum logic [2:0] {
    CFG_ALPHA  = 3'd0,
    CFG_COEF0  = 3'd1,
    CFG_COEF1  = 3'd2,
    CFG_COEF2  = 3'd3,
    CFG_COEF3  = 3'd4,
    CFG_COEF4  = 3'd5,
    CFG_COUNT  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic       busy;
    logic       alpha_nz;
    logic [2:0] count;
  } cfg_stat_t;

  // Position of the highest set bit; 0 for an all-zero word.
  function automatic logic [6:0] msb128(input logic [127:0] x);
    logic [6:0] k;
    k = '0;
    for (int i = 0; i < 128; i++) begin
      if (x[i]) k = 7'(i);
    end
    return k;
  endfunction

  // Right shift by a non-negative amount, lost bits or-ed into bit 0.
  function automatic logic [127:0] jam_shr(input logic [127:0] x, input logic [13:0] d);
    logic [7:0]   amt;
    logic [127:0] r;
    logic [127:0] mask;
    amt  = (d > 14'd127) ? 8'd128 : 8'(d);
    r    = x >> amt;
    mask = ~({128{1'b1}} << amt);
    r[0] = r[0] | (|(x & mask));
    return r;
  endfunction

endpackage

[sv/fax_intf.sv]
interface fax_row_if;
  logic        valid;
  logic        ready;
  logic [63:0] y_in;
  logic [63:0] mat_col_zero;
  logic [63:0] mat_col_one;
  logic [63:0] mat_col_two;
  logic [63:0] mat_col_three;
  logic [63:0] mat_col_four;
  logic        last_row_in;
  modport source (output valid, y_in, mat_col_zero, mat_col_one, mat_col_two,
                  mat_col_three, mat_col_four, last_row_in, input ready);
  modport sink   (input valid, y_in, mat_col_zero, mat_col_one, mat_col_two,
                  mat_col_three, mat_col_four, last_row_in, output ready);
endinterface

interface fax_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] y_out;
  logic        last_row_out;
  modport source (output valid, y_out, last_row_out, input ready);
  modport sink   (input valid, y_out, last_row_out, output ready);
endinterface

interface fax_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/fax_fma.sv]
module fax_fma #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [63:0]       a_i,
  input  logic [63:0]       b_i,
  input  logic [63:0]       c_i,
  input  logic              bypass_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [63:0]       res_o,
  output logic [SIDE_W-1:0] side_o
);
  import fax_pkg::*;

  logic [FMA_LAT-1:0] vld_q;
  logic [SIDE_W-1:0]  side_q [FMA_LAT];

  // ---- stage 1: unpack, specials, partial products
  logic        sa, sb, sc, ps;
  logic [10:0] ea, eb, ec, ea1, eb1, ec1;
  logic [51:0] fa, fb, fc;
  logic        az, bz, cz, spec;
  logic [63:0] sval;
  logic [52:0] ma, mb, mc;
  logic [53:0] ll_d;
  logic [52:0] lh_d, hl_d;
  logic [51:0] hh_d;

  always_comb begin
    sa = a_i[63]; sb = b_i[63]; sc = c_i[63]; ps = sa ^ sb;
    ea = a_i[62:52]; eb = b_i[62:52]; ec = c_i[62:52];
    fa = a_i[51:0];  fb = b_i[51:0];  fc = c_i[51:0];
    az = (ea == 11'd0) && (fa == 52'd0);
    bz = (eb == 11'd0) && (fb == 52'd0);
    cz = (ec == 11'd0) && (fc == 52'd0);
    ea1 = (ea == 11'd0) ? 11'd1 : ea;
    eb1 = (eb == 11'd0) ? 11'd1 : eb;
    ec1 = (ec == 11'd0) ? 11'd1 : ec;
    ma = {(ea != 11'd0), fa};
    mb = {(eb != 11'd0), fb};
    mc = {(ec != 11'd0), fc};
    spec = 1'b1;
    sval = c_i;
    if (bypass_i) begin
      sval = c_i;
    end else if (((ea == 11'h7FF) && (fa != 52'd0)) || ((eb == 11'h7FF) && (fb != 52'd0))
                 || ((ec == 11'h7FF) && (fc != 52'd0))) begin
      sval = QNAN_BITS;
    end else if ((ea == 11'h7FF) || (eb == 11'h7FF)) begin
      if (az || bz) sval = QNAN_BITS;
      else if ((ec == 11'h7FF) && (sc != ps)) sval = QNAN_BITS;
      else sval = {ps, INF_MAG};
    end else if (ec == 11'h7FF) begin
      sval = c_i;
    end else if (az || bz) begin
      sval = cz ? {ps & sc, 63'd0} : c_i;
    end else begin
      spec = 1'b0;
    end
    ll_d = ma[26:0] * mb[26:0];
    lh_d = ma[26:0] * mb[52:27];
    hl_d = ma[52:27] * mb[26:0];
    hh_d = ma[52:27] * mb[52:27];
  end

  logic [53:0] s1_ll_q;
  logic [52:0] s1_lh_q, s1_hl_q, s1_mc_q;
  logic [51:0] s1_hh_q;
  logic [11:0] s1_xab_q;
  logic [10:0] s1_ec_q;
  logic        s1_ps_q, s1_sc_q, s1_cz_q, s1_spec_q;
  logic [63:0] s1_sval_q;

  // ---- stage 2: product sum, lead bit of addend
  logic [105:0] p_sum;
  assign p_sum = 106'(s1_ll_q) + (106'(s1_lh_q) << 27) + (106'(s1_hl_q) << 27)
               + (106'(s1_hh_q) << 54);

  logic [105:0] s2_p_q;
  logic [52:0]  s2_mc_q;
  logic [6:0]   s2_kc_q;
  expo_t        s2_xp_q, s2_xc_q;
  logic         s2_ps_q, s2_sc_q, s2_cz_q, s2_spec_q;
  logic [63:0]  s2_sval_q;

  // ---- stage 3: lead bit of product, normalise addend
  logic [105:0] s3_p_q;
  logic [6:0]   s3_kp_q;
  logic [127:0] s3_mc_q;
  expo_t        s3_xp_q, s3_xc_q;
  logic         s3_ps_q, s3_sc_q, s3_cz_q, s3_spec_q;
  logic [63:0]  s3_sval_q;

  // ---- stage 4: normalise product
  logic [127:0] s4_p_q, s4_mc_q;
  expo_t        s4_xp_q, s4_xc_q;
  logic         s4_ps_q, s4_sc_q, s4_cz_q, s4_spec_q;
  logic [63:0]  s4_sval_q;

  // ---- stage 5: alignment
  expo_t        dx;
  logic [127:0] al_p, al_c;
  expo_t        al_e;
  always_comb begin
    dx = s4_xp_q - s4_xc_q;
    al_p = s4_p_q;
    al_c = s4_mc_q;
    al_e = s4_xp_q;
    if (s4_cz_q) begin
      al_c = '0;
    end else if (!dx[13]) begin
      al_c = jam_shr(s4_mc_q, dx);
    end else begin
      al_p = jam_shr(s4_p_q, 14'(-dx));
      al_e = s4_xc_q;
    end
  end

  logic [127:0] s5_p_q, s5_c_q;
  expo_t        s5_e_q;
  logic         s5_ps_q, s5_sc_q, s5_spec_q;
  logic [63:0]  s5_sval_q;

  // ---- stage 6: add or subtract magnitudes
  logic [127:0] ad_m;
  logic         ad_s, ad_z;
  always_comb begin
    ad_z = 1'b0;
    if (s5_ps_q == s5_sc_q) begin
      ad_m = s5_p_q + s5_c_q;
      ad_s = s5_ps_q;
    end else if (s5_p_q > s5_c_q) begin
      ad_m = s5_p_q - s5_c_q;
      ad_s = s5_ps_q;
    end else begin
      ad_m = s5_c_q - s5_p_q;
      ad_s = s5_sc_q;
      ad_z = (s5_p_q == s5_c_q);
    end
  end

  logic [127:0] s6_m_q;
  expo_t        s6_e_q;
  logic         s6_s_q, s6_z_q, s6_spec_q;
  logic [63:0]  s6_sval_q;

  // ---- stage 7: lead bit of sum
  logic [127:0] s7_m_q;
  logic [6:0]   s7_km_q;
  expo_t        s7_e_q;
  logic         s7_s_q, s7_z_q, s7_spec_q;
  logic [63:0]  s7_sval_q;

  // ---- stage 8: rounding position, guard and sticky
  expo_t       km_e, be, sh;
  logic        norm, ovf, inc, gbit, stk;
  logic [52:0] q;
  logic [10:0] ef;
  logic [7:0]  amt;
  always_comb begin
    km_e = expo_t'({7'd0, s7_km_q}) + s7_e_q;
    norm = (km_e >= -14'sd1022);
    be   = km_e + 14'sd1023;
    ovf  = norm && (be >= 14'sd2047);
    sh   = norm ? (expo_t'({7'd0, s7_km_q}) - 14'sd52) : (-14'sd1074 - s7_e_q);
    ef   = norm ? 11'(be - 14'sd1) : 11'd0;
    amt  = 8'(sh);
    gbit = 1'b0;
    stk  = 1'b0;
    inc  = 1'b0;
    if (sh <= 14'sd0) begin
      q = 53'(s7_m_q << 6'(-sh));
    end else if (sh > 14'sd128) begin
      q = '0;
    end else begin
      q    = 53'(s7_m_q >> amt);
      gbit = s7_m_q[7'(amt - 8'd1)];
      stk  = |(s7_m_q & ~({128{1'b1}} << (amt - 8'd1)));
      inc  = gbit & (stk | q[0]);
    end
  end

  logic [52:0] s8_q_q;
  logic [10:0] s8_ef_q;
  logic        s8_inc_q, s8_ovf_q, s8_s_q, s8_z_q, s8_spec_q;
  logic [63:0] s8_sval_q;

  // ---- stage 9: final pack
  logic [62:0] mag;
  logic [63:0] fin;
  always_comb begin
    mag = {s8_ef_q, 52'd0} + 63'(s8_q_q) + 63'(s8_inc_q);
    if (s8_spec_q)     fin = s8_sval_q;
    else if (s8_z_q)   fin = '0;
    else if (s8_ovf_q) fin = {s8_s_q, INF_MAG};
    else               fin = {s8_s_q, mag};
  end

  logic [63:0] s9_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FMA_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < FMA_LAT; k++) side_q[k] <= side_q[k-1];
      // 1
      s1_ll_q <= ll_d; s1_lh_q <= lh_d; s1_hl_q <= hl_d; s1_hh_q <= hh_d;
      s1_xab_q <= 12'(ea1) + 12'(eb1);
      s1_ec_q <= ec1; s1_mc_q <= mc;
      s1_ps_q <= ps; s1_sc_q <= sc; s1_cz_q <= cz;
      s1_spec_q <= spec; s1_sval_q <= sval;
      // 2
      s2_p_q  <= p_sum;
      s2_mc_q <= s1_mc_q;
      s2_kc_q <= msb128(128'(s1_mc_q));
      s2_xp_q <= expo_t'({2'b00, s1_xab_q}) - 14'sd2150;
      s2_xc_q <= expo_t'({3'b000, s1_ec_q}) - 14'sd1075;
      s2_ps_q <= s1_ps_q; s2_sc_q <= s1_sc_q; s2_cz_q <= s1_cz_q;
      s2_spec_q <= s1_spec_q; s2_sval_q <= s1_sval_q;
      // 3
      s3_p_q  <= s2_p_q;
      s3_kp_q <= msb128(128'(s2_p_q));
      s3_mc_q <= 128'(s2_mc_q) << (7'd126 - s2_kc_q);
      s3_xc_q <= s2_xc_q - expo_t'({7'd0, 7'd126 - s2_kc_q});
      s3_xp_q <= s2_xp_q;
      s3_ps_q <= s2_ps_q; s3_sc_q <= s2_sc_q; s3_cz_q <= s2_cz_q;
      s3_spec_q <= s2_spec_q; s3_sval_q <= s2_sval_q;
      // 4
      s4_p_q  <= 128'(s3_p_q) << (7'd126 - s3_kp_q);
      s4_xp_q <= s3_xp_q - expo_t'({7'd0, 7'd126 - s3_kp_q});
      s4_mc_q <= s3_mc_q; s4_xc_q <= s3_xc_q;
      s4_ps_q <= s3_ps_q; s4_sc_q <= s3_sc_q; s4_cz_q <= s3_cz_q;
      s4_spec_q <= s3_spec_q; s4_sval_q <= s3_sval_q;
      // 5
      s5_p_q <= al_p; s5_c_q <= al_c; s5_e_q <= al_e;
      s5_ps_q <= s4_ps_q; s5_sc_q <= s4_sc_q;
      s5_spec_q <= s4_spec_q; s5_sval_q <= s4_sval_q;
      // 6
      s6_m_q <= ad_m; s6_s_q <= ad_s; s6_z_q <= ad_z; s6_e_q <= s5_e_q;
      s6_spec_q <= s5_spec_q; s6_sval_q <= s5_sval_q;
      // 7
      s7_m_q <= s6_m_q; s7_km_q <= msb128(s6_m_q); s7_e_q <= s6_e_q;
      s7_s_q <= s6_s_q; s7_z_q <= s6_z_q;
      s7_spec_q <= s6_spec_q; s7_sval_q <= s6_sval_q;
      // 8
      s8_q_q <= q; s8_ef_q <= ef; s8_inc_q <= inc; s8_ovf_q <= ovf;
      s8_s_q <= s7_s_q; s8_z_q <= s7_z_q;
      s8_spec_q <= s7_spec_q; s8_sval_q <= s7_sval_q;
      // 9
      s9_res_q <= fin;
    end
  end

  assign valid_o = vld_q[FMA_LAT-1];
  assign res_o   = s9_res_q;
  assign side_o  = side_q[FMA_LAT-1];

endmodule

[sv/fax_coef.sv]
module fax_coef #(
  parameter int unsigned NCOL = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  fax_cfg_if.sink            cfg_i,
  output fax_pkg::cfg_stat_t stat_o,
  output logic [63:0]        coef_o [fax_pkg::FIELD_COLS]
);
  import fax_pkg::*;

  localparam int unsigned TOTAL = NCOL + FMA_LAT;
  localparam int unsigned CNT_W = $clog2(TOTAL + 1);

  logic [63:0]      alpha_q, alpha_d;
  logic [63:0]      x_q [FIELD_COLS];
  logic [63:0]      x_d [FIELD_COLS];
  logic [2:0]       count_q, count_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [63:0]      coef_q [FIELD_COLS];
  logic             wr;
  cfg_idx_e         idx;

  logic                 iss_vld, ret_vld;
  logic [COL_IDX_W-1:0] iss_idx, ret_idx;
  logic [63:0]          ret_val;

  assign cfg_i.ready = 1'b1;
  assign wr  = cfg_i.valid;
  assign idx = cfg_idx_e'(cfg_i.index);

  always_comb begin
    alpha_d = alpha_q;
    x_d     = x_q;
    count_d = count_q;
    if (wr) begin
      unique case (idx) inside
        CFG_ALPHA: alpha_d = cfg_i.data;
        CFG_COEF0, CFG_COEF1, CFG_COEF2, CFG_COEF3, CFG_COEF4:
          x_d[COL_IDX_W'(idx - CFG_COEF0)] = cfg_i.data;
        CFG_COUNT: count_d = cfg_i.data[2:0];
        default: ;
      endcase
    end
    // any write restarts the coefficient sweep
    if (wr)                        cnt_d = '0;
    else if (cnt_q < CNT_W'(TOTAL)) cnt_d = cnt_q + 1'b1;
    else                           cnt_d = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
      for (int j = 0; j < FIELD_COLS; j++) x_q[j] <= '0;
      count_q <= 3'd5;
      cnt_q   <= CNT_W'(TOTAL);
    end else begin
      alpha_q <= alpha_d;
      x_q     <= x_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
    end
  end

  assign iss_vld = (cnt_q < CNT_W'(NCOL));
  assign iss_idx = COL_IDX_W'(cnt_q);

  // c_j = round(alpha * x_j), the -0 addend keeps the product exact sign rules
  fax_fma #(.SIDE_W(COL_IDX_W)) u_fma (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (1'b1),
    .valid_i  (iss_vld),
    .a_i      (alpha_q),
    .b_i      (x_q[iss_idx]),
    .c_i      (SIGN_BIT),
    .bypass_i (1'b0),
    .side_i   (iss_idx),
    .valid_o  (ret_vld),
    .res_o    (ret_val),
    .side_o   (ret_idx)
  );

  always_ff @(posedge clk_i) begin
    if (ret_vld) coef_q[ret_idx] <= ret_val;
  end

  assign coef_o          = coef_q;
  assign stat_o.busy     = (cnt_q < CNT_W'(TOTAL));
  assign stat_o.alpha_nz = (alpha_q[62:0] != 63'd0);
  assign stat_o.count    = count_q;

endmodule

[sv/fused_axpy_five_column_double.sv]
// Each column slot is one fused multiply-add pipeline, active or bypassed; MAX_COLUMNS
//   (capped at five) slots stand in a row between an accepted row and its result.
// Throughput: one row per cycle, unless the output stalls or a config sweep runs.
// A config write re-runs the coefficient unit, holding rows off until its sweep ends.
// Reset: asynchronous, active low; alpha and x cleared, column count 5, pipelines empty.
module fused_axpy_five_column_double #(
  parameter int unsigned MAX_COLUMNS = fax_pkg::DEF_MAX_COLUMNS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fax_row_if.sink  row_i,
  fax_res_if.source res_o,
  fax_cfg_if.sink  cfg_i
);
  import fax_pkg::*;

  // Only five column fields exist on the row, whatever the parameter says.
  localparam int unsigned NCOL   = (MAX_COLUMNS < FIELD_COLS) ? MAX_COLUMNS : FIELD_COLS;
  localparam int unsigned SIDE_W = NCOL * 64 + 1;

  cfg_stat_t   stat;
  logic [63:0] coef [FIELD_COLS];

  // Config registers and the coefficient unit: c_j = round(alpha * x_j).
  fax_coef #(.NCOL(NCOL)) u_coef (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .stat_o (stat),
    .coef_o (coef)
  );

  // Global advance: the last pipeline stage is the output register, so the whole
  // chain moves whenever that register is empty or being drained.
  logic en;
  assign en          = !res_o.valid || res_o.ready;
  assign row_i.ready = en && !stat.busy;

  logic [5*64-1:0] mats;
  assign mats = {row_i.mat_col_four, row_i.mat_col_three, row_i.mat_col_two,
                 row_i.mat_col_one, row_i.mat_col_zero};

  // Buses between column slots: y travels in the datapath, the row's matrix
  // elements and the last-row mark travel as sideband.
  logic              vld_bus  [NCOL+1];
  logic [63:0]       y_bus    [NCOL+1];
  logic [SIDE_W-1:0] side_bus [NCOL+1];

  assign vld_bus[0]  = row_i.valid && row_i.ready;
  assign y_bus[0]    = row_i.y_in;
  assign side_bus[0] = {row_i.last_row_in, mats[NCOL*64-1:0]};

  for (genvar j = 0; j < NCOL; j++) begin : g_col
    logic act;
    // A column outside the count, or a zero alpha, lets y through untouched.
    assign act = stat.alpha_nz && (3'(j) < stat.count);

    fax_fma #(.SIDE_W(SIDE_W)) u_fma (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (vld_bus[j]),
      .a_i      (side_bus[j][j*64 +: 64]),
      .b_i      (coef[j]),
      .c_i      (y_bus[j]),
      .bypass_i (!act),
      .side_i   (side_bus[j]),
      .valid_o  (vld_bus[j+1]),
      .res_o    (y_bus[j+1]),
      .side_o   (side_bus[j+1])
    );
  end

  assign res_o.valid        = vld_bus[NCOL];
  assign res_o.y_out        = y_bus[NCOL];
  assign res_o.last_row_out = side_bus[NCOL][SIDE_W-1];

endmodule
